/* design/ll1p_pkg.sv */
// ----------------------------------------------------------------------------
// ll1p_pkg
// Shared codes, field widths and types of the LL(1) predictive parse engine.
// ----------------------------------------------------------------------------
package ll1p_pkg;

	localparam int OP_W      = 3;
	localparam int NT_W      = 4;
	localparam int TERM_W    = 5;
	localparam int KIND_W    = 2;
	localparam int PROD_W    = 6;
	localparam int POS_W     = 3;
	localparam int SYM_W     = 6;
	localparam int LEN_W     = 4;
	localparam int STATUS_W  = 2;
	localparam int IERR_W    = 8;
	localparam int TERR_W    = 16;
	localparam int EKIND_W   = 3;
	localparam int STEP_W    = 14;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 14;

	// input operations
	localparam logic [OP_W-1:0] OP_LOAD_CELL = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_SYM  = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD_LEN  = 3'd2;
	localparam logic [OP_W-1:0] OP_START     = 3'd3;
	localparam logic [OP_W-1:0] OP_TOKEN     = 3'd4;
	localparam logic [OP_W-1:0] OP_END       = 3'd5;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IDLE   = 2'd3;

	// error kinds
	localparam logic [EKIND_W-1:0] ERR_NONE     = 3'd0;
	localparam logic [EKIND_W-1:0] ERR_MISMATCH = 3'd1;
	localparam logic [EKIND_W-1:0] ERR_EMPTY    = 3'd2;
	localparam logic [EKIND_W-1:0] ERR_CONFLICT = 3'd3;
	localparam logic [EKIND_W-1:0] ERR_OVERFLOW = 3'd4;
	localparam logic [EKIND_W-1:0] ERR_LIMIT    = 3'd5;

	// parse table cell kinds
	localparam logic [KIND_W-1:0] CELL_EMPTY  = 2'd0;
	localparam logic [KIND_W-1:0] CELL_SINGLE = 2'd1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_SYMBOL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT   = 1'd1;

	localparam logic [SYM_W-1:0]  SYM_END_MARK = 6'd0;
	localparam logic [SYM_W-1:0]  NT_BASE      = 6'd32;
	localparam logic [STEP_W-1:0] STEP_MAX     = 14'd16383;
	localparam logic [STEP_W-1:0] LIMIT_RST    = 14'd10000;
	localparam logic [IERR_W-1:0] IERR_MAX     = 8'd255;
	localparam logic [TERR_W-1:0] TERR_MAX     = 16'd65535;

	typedef struct packed {
		logic               clr_item;
		logic               clr_all;
		logic               note;
		logic [EKIND_W-1:0] kind;
		logic [SYM_W-1:0]   top;
	} err_cmd_t;

	typedef struct packed {
		logic [IERR_W-1:0]  item_errs;
		logic [TERR_W-1:0]  total;
		logic [EKIND_W-1:0] kind;
		logic [SYM_W-1:0]   top;
	} err_info_t;

endpackage

/* design/ll1p_cmd_if.sv */
// ----------------------------------------------------------------------------
// ll1p_cmd_if
// Input item channel: load, start, token and end items.
// ----------------------------------------------------------------------------
interface ll1p_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [ll1p_pkg::OP_W-1:0]     op;
	logic [ll1p_pkg::NT_W-1:0]     nonterminal;
	logic [ll1p_pkg::TERM_W-1:0]   terminal;
	logic [ll1p_pkg::KIND_W-1:0]   cell_kind;
	logic [ll1p_pkg::PROD_W-1:0]   prod_index;
	logic [ll1p_pkg::POS_W-1:0]    position;
	logic [ll1p_pkg::SYM_W-1:0]    symbol;
	logic [ll1p_pkg::LEN_W-1:0]    length;

	modport source (output valid, op, nonterminal, terminal, cell_kind, prod_index,
		position, symbol, length, input ready);
	modport sink (input valid, op, nonterminal, terminal, cell_kind, prod_index,
		position, symbol, length, output ready);
endinterface

/* design/ll1p_res_if.sv */
// ----------------------------------------------------------------------------
// ll1p_res_if
// Result item channel: status and error bookkeeping per parse item.
// ----------------------------------------------------------------------------
interface ll1p_res_if;
	logic                        valid;
	logic                        ready;
	logic [ll1p_pkg::STATUS_W-1:0]   status;
	logic [ll1p_pkg::IERR_W-1:0]     item_errors;
	logic [ll1p_pkg::TERR_W-1:0]     total_errors;
	logic [ll1p_pkg::EKIND_W-1:0]    last_error_kind;
	logic [ll1p_pkg::SYM_W-1:0]      last_error_top;
	logic [ll1p_pkg::STEP_W-1:0]     steps_used;

	modport source (output valid, status, item_errors, total_errors, last_error_kind,
		last_error_top, steps_used, input ready);
	modport sink (input valid, status, item_errors, total_errors, last_error_kind,
		last_error_top, steps_used, output ready);
endinterface

/* design/ll1p_err_rec.sv */
// ----------------------------------------------------------------------------
// ll1p_err_rec
// Error recorder: saturating per-item and per-parse counts, last kind and top.
// ----------------------------------------------------------------------------
module ll1p_err_rec (
	input  logic               clk,
	input  logic               arst_n,
	input  ll1p_pkg::err_cmd_t  cmd,
	output ll1p_pkg::err_info_t info
);
	import ll1p_pkg::*;

	logic [IERR_W-1:0]  item_q;
	logic [TERR_W-1:0]  total_q;
	logic [EKIND_W-1:0] kind_q;
	logic [SYM_W-1:0]   top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q  <= '0;
			total_q <= '0;
			kind_q  <= ERR_NONE;
			top_q   <= '0;
		end else begin
			if (cmd.clr_item) begin
				item_q <= '0;
			end
			if (cmd.clr_all) begin
				total_q <= '0;
				kind_q  <= ERR_NONE;
				top_q   <= '0;
			end
			if (cmd.note) begin
				if (item_q != IERR_MAX) item_q <= item_q + 1'b1;
				if (total_q != TERR_MAX) total_q <= total_q + 1'b1;
				kind_q <= cmd.kind;
				top_q  <= cmd.top;
			end
		end
	end

	assign info.item_errs = item_q;
	assign info.total     = total_q;
	assign info.kind      = kind_q;
	assign info.top       = top_q;

endmodule

/* design/ll1_predictive_parse_engine_top.sv */
// ----------------------------------------------------------------------------
// ll1_predictive_parse_engine_top
// Table-driven LL(1) parser with on-chip parse table, production store and
// symbol stack, run by a small step sequencer.
// ----------------------------------------------------------------------------
// Load items write the parse table, production symbols or production lengths
// in the cycle they transfer and give no result. A start item pushes the end
// marker, then the start symbol. Token and end items run parse steps one at a
// time through the symbol stack and registered table reads: a terminal step
// passes S_STEP, S_TOP and S_CHK, an expansion also S_CELL, S_LEN and an
// S_PUSH, S_PWR pair per pushed symbol; S_EMIT hands the result to the output
// register. The input is not ready while a step sequence runs; it is ready
// again while a finished result still waits on the output side.
module ll1_predictive_parse_engine_top #(
	parameter int NUM_NONTERMINALS = 16,
	parameter int NUM_TERMINALS    = 32,
	parameter int MAX_PRODUCTIONS  = 64,
	parameter int MAX_PROD_LEN     = 8,
	parameter int STACK_DEPTH      = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ll1p_cmd_if.sink                       cmd,
	ll1p_res_if.source                     res,
	input  logic                           wr_en,
	input  logic [ll1p_pkg::CFG_IDX_W-1:0] wr_idx,
	input  logic [ll1p_pkg::CFG_W-1:0]     wr_data
);
	import ll1p_pkg::*;

	localparam int TBL_D = NUM_NONTERMINALS * NUM_TERMINALS;
	localparam int PS_D  = MAX_PRODUCTIONS * MAX_PROD_LEN;
	localparam int TA_W  = (TBL_D > 1) ? $clog2(TBL_D) : 1;
	localparam int PSA_W = (PS_D > 1) ? $clog2(PS_D) : 1;
	localparam int PLA_W = (MAX_PRODUCTIONS > 1) ? $clog2(MAX_PRODUCTIONS) : 1;
	localparam int SA_W  = $clog2(STACK_DEPTH);
	localparam int SP_W  = $clog2(STACK_DEPTH + 1);
	localparam int CNT_W = $clog2(MAX_PROD_LEN + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ST0  = 4'd1;
	localparam logic [3:0] S_ST1  = 4'd2;
	localparam logic [3:0] S_STEP = 4'd3;
	localparam logic [3:0] S_TOP  = 4'd4;
	localparam logic [3:0] S_CELL = 4'd5;
	localparam logic [3:0] S_LEN  = 4'd6;
	localparam logic [3:0] S_PUSH = 4'd7;
	localparam logic [3:0] S_PWR  = 4'd8;
	localparam logic [3:0] S_CHK  = 4'd9;
	localparam logic [3:0] S_LIM  = 4'd10;
	localparam logic [3:0] S_EMIT = 4'd11;

	// configuration
	logic [NT_W-1:0]   start_q;
	logic [STEP_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			limit_q <= LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_START_SYMBOL: start_q <= wr_data[NT_W-1:0];
				REG_STEP_LIMIT:   limit_q <= wr_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer registers
	logic [3:0]          state_q, state_d;
	logic [SP_W-1:0]     sp_q, sp_d;
	logic [STEP_W-1:0]   steps_q, steps_d;
	logic                active_q, active_d;
	logic                at_end_q, at_end_d;
	logic [TERM_W-1:0]   tok_q, tok_d;
	logic [SYM_W-1:0]    x_q, x_d;
	logic [PROD_W-1:0]   p_q, p_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                consumed_q, consumed_d;
	logic                cell_ok_q, cell_ok_d;
	logic [STATUS_W-1:0] status_q, status_d;

	logic acc;
	logic emit_fire;
	assign cmd.ready = (state_q == S_IDLE);
	assign acc       = cmd.valid && cmd.ready;

	// memories
	logic [KIND_W+PROD_W-1:0] tbl_mem [TBL_D];
	logic [SYM_W-1:0]         sym_mem [PS_D];
	logic [CNT_W-1:0]         len_mem [MAX_PRODUCTIONS];
	logic [SYM_W-1:0]         stk_mem [STACK_DEPTH];
	logic [KIND_W+PROD_W-1:0] tbl_rd_q;
	logic [SYM_W-1:0]         sym_rd_q;
	logic [CNT_W-1:0]         len_rd_q;
	logic [SYM_W-1:0]         stk_rd_q;

	logic [TA_W-1:0]  tbl_ra, tbl_wa;
	logic [PSA_W-1:0] sym_ra, sym_wa;
	logic [SA_W-1:0]  stk_ra, stk_wa;
	logic [SYM_W-1:0] stk_wd;
	logic             stk_we;
	logic [CNT_W-1:0] len_wd;

	assign tbl_wa = TA_W'(32'(cmd.nonterminal) * NUM_TERMINALS + 32'(cmd.terminal));
	assign sym_wa = PSA_W'(32'(cmd.prod_index) * MAX_PROD_LEN + 32'(cmd.position));
	assign len_wd = (32'(cmd.length) > MAX_PROD_LEN) ? CNT_W'(MAX_PROD_LEN)
		: CNT_W'(cmd.length);
	// row of the nonterminal on top is its id minus the base
	assign tbl_ra = TA_W'(32'(stk_rd_q[4:0]) * NUM_TERMINALS + 32'(tok_q));
	assign sym_ra = PSA_W'(32'(p_q) * MAX_PROD_LEN + 32'(cnt_q) - 1);
	assign stk_ra = SA_W'(sp_q - 1'b1);

	always_ff @(posedge clk) begin
		if (acc && cmd.op == OP_LOAD_CELL && 32'(cmd.nonterminal) < NUM_NONTERMINALS
			&& 32'(cmd.terminal) < NUM_TERMINALS) begin
			tbl_mem[tbl_wa] <= {cmd.cell_kind, cmd.prod_index};
		end
		if (acc && cmd.op == OP_LOAD_SYM && 32'(cmd.prod_index) < MAX_PRODUCTIONS
			&& 32'(cmd.position) < MAX_PROD_LEN) begin
			sym_mem[sym_wa] <= cmd.symbol;
		end
		if (acc && cmd.op == OP_LOAD_LEN && 32'(cmd.prod_index) < MAX_PRODUCTIONS) begin
			len_mem[PLA_W'(cmd.prod_index)] <= len_wd;
		end
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		tbl_rd_q <= tbl_mem[tbl_ra];
		sym_rd_q <= sym_mem[sym_ra];
		len_rd_q <= len_mem[PLA_W'(tbl_rd_q[PROD_W-1:0])];
		stk_rd_q <= stk_mem[stk_ra];
	end

	// error recorder
	err_cmd_t  err_cmd;
	err_info_t err_info;

	ll1p_err_rec u_err (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (err_cmd),
		.info   (err_info)
	);

	// step sequencer
	logic [KIND_W-1:0] ckind;
	logic [PROD_W-1:0] cprod;
	logic              lim_hit;

	always_comb begin
		state_d    = state_q;
		sp_d       = sp_q;
		steps_d    = steps_q;
		active_d   = active_q;
		at_end_d   = at_end_q;
		tok_d      = tok_q;
		x_d        = x_q;
		p_d        = p_q;
		cnt_d      = cnt_q;
		consumed_d = consumed_q;
		cell_ok_d  = cell_ok_q;
		status_d   = status_q;
		err_cmd    = '0;
		stk_we     = 1'b0;
		stk_wa     = SA_W'(sp_q);
		stk_wd     = sym_rd_q;
		emit_fire  = 1'b0;
		ckind      = cell_ok_q ? tbl_rd_q[KIND_W+PROD_W-1:PROD_W] : CELL_EMPTY;
		cprod      = tbl_rd_q[PROD_W-1:0];
		if (ckind == CELL_SINGLE && 32'(cprod) >= MAX_PRODUCTIONS) ckind = CELL_EMPTY;
		lim_hit    = (steps_q > limit_q) || (steps_q == STEP_MAX);

		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					err_cmd.clr_item = 1'b1;
					unique case (cmd.op)
						OP_START: begin
							err_cmd.clr_all = 1'b1;
							state_d         = S_ST0;
						end
						OP_TOKEN, OP_END: begin
							at_end_d = (cmd.op == OP_END);
							tok_d    = (cmd.op == OP_END) ? SYM_END_MARK[TERM_W-1:0]
								: cmd.terminal;
							if (active_q) begin
								state_d = S_STEP;
							end else begin
								status_d = ST_IDLE;
								state_d  = S_EMIT;
							end
						end
						default: ;
					endcase
				end
			end
			S_ST0: begin
				stk_we  = 1'b1;
				stk_wa  = '0;
				stk_wd  = SYM_END_MARK;
				state_d = S_ST1;
			end
			S_ST1: begin
				stk_we   = 1'b1;
				stk_wa   = SA_W'(1);
				stk_wd   = NT_BASE | SYM_W'(start_q);
				sp_d     = SP_W'(2);
				steps_d  = '0;
				active_d = 1'b1;
				status_d = ST_OK;
				state_d  = S_EMIT;
			end
			S_STEP: begin
				if (steps_q != STEP_MAX) steps_d = steps_q + 1'b1;
				if (sp_q == '0) begin
					active_d = 1'b0;
					status_d = ST_REJECT;
					state_d  = S_EMIT;
				end else begin
					state_d = S_TOP;
				end
			end
			S_TOP: begin
				x_d        = stk_rd_q;
				consumed_d = 1'b0;
				if (stk_rd_q == SYM_END_MARK && tok_q == '0) begin
					active_d = 1'b0;
					status_d = ST_ACCEPT;
					state_d  = S_EMIT;
				end else if (stk_rd_q < NT_BASE) begin
					sp_d = sp_q - 1'b1;
					if (stk_rd_q == SYM_W'(tok_q)) begin
						consumed_d = 1'b1;
					end else begin
						err_cmd.note = 1'b1;
						err_cmd.kind = ERR_MISMATCH;
						err_cmd.top  = stk_rd_q;
						consumed_d   = !at_end_q;
					end
					state_d = S_CHK;
				end else begin
					cell_ok_d = (32'(stk_rd_q[4:0]) < NUM_NONTERMINALS)
						&& (32'(tok_q) < NUM_TERMINALS);
					state_d   = S_CELL;
				end
			end
			S_CELL: begin
				if (ckind == CELL_EMPTY) begin
					err_cmd.note = 1'b1;
					err_cmd.kind = ERR_EMPTY;
					err_cmd.top  = x_q;
					if (at_end_q) begin
						active_d = 1'b0;
						status_d = ST_REJECT;
						state_d  = S_EMIT;
					end else begin
						consumed_d = 1'b1;
						state_d    = S_CHK;
					end
				end else if (ckind != CELL_SINGLE) begin
					err_cmd.note = 1'b1;
					err_cmd.kind = ERR_CONFLICT;
					err_cmd.top  = x_q;
					consumed_d   = !at_end_q;
					state_d      = S_CHK;
				end else begin
					sp_d    = sp_q - 1'b1;
					p_d     = cprod;
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				if (32'(sp_q) + 32'(len_rd_q) > STACK_DEPTH) begin
					err_cmd.note = 1'b1;
					err_cmd.kind = ERR_OVERFLOW;
					err_cmd.top  = x_q;
					active_d     = 1'b0;
					status_d     = ST_REJECT;
					state_d      = S_EMIT;
				end else begin
					cnt_d   = len_rd_q;
					state_d = (len_rd_q == '0) ? S_CHK : S_PUSH;
				end
			end
			S_PUSH: begin
				state_d = S_PWR;
			end
			S_PWR: begin
				// rightmost symbol first
				stk_we  = 1'b1;
				sp_d    = sp_q + 1'b1;
				cnt_d   = cnt_q - 1'b1;
				state_d = (cnt_q == CNT_W'(1)) ? S_CHK : S_PUSH;
			end
			S_CHK: begin
				if (lim_hit) begin
					if (sp_q != '0) begin
						state_d = S_LIM;
					end else begin
						err_cmd.note = 1'b1;
						err_cmd.kind = ERR_LIMIT;
						err_cmd.top  = x_q;
						active_d     = 1'b0;
						status_d     = ST_REJECT;
						state_d      = S_EMIT;
					end
				end else if (consumed_q) begin
					status_d = ST_OK;
					state_d  = S_EMIT;
				end else begin
					state_d = S_STEP;
				end
			end
			S_LIM: begin
				err_cmd.note = 1'b1;
				err_cmd.kind = ERR_LIMIT;
				err_cmd.top  = stk_rd_q;
				active_d     = 1'b0;
				status_d     = ST_REJECT;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (!res.valid || res.ready) begin
					emit_fire = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sp_q       <= '0;
			steps_q    <= '0;
			active_q   <= 1'b0;
			consumed_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			sp_q       <= sp_d;
			steps_q    <= steps_d;
			active_q   <= active_d;
			consumed_q <= consumed_d;
		end
	end

	always_ff @(posedge clk) begin
		at_end_q  <= at_end_d;
		tok_q     <= tok_d;
		x_q       <= x_d;
		p_q       <= p_d;
		cnt_q     <= cnt_d;
		cell_ok_q <= cell_ok_d;
		status_q  <= status_d;
	end

	// output register
	logic res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			res.status          <= status_q;
			res.item_errors     <= err_info.item_errs;
			res.total_errors    <= err_info.total;
			res.last_error_kind <= err_info.kind;
			res.last_error_top  <= err_info.top;
			res.steps_used      <= steps_q;
		end
	end

	assign res.valid = res_valid_q;

	// checks
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= STACK_DEPTH)
		else $error("stack pointer beyond stack depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PWR |-> 32'(sp_q) < STACK_DEPTH)
		else $error("push without room on the stack");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire && (status_q == ST_ACCEPT || status_q == ST_REJECT) |-> !active_q)
		else $error("parse still active after accept or reject");

	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> res.valid && res.status == $past(status_q))
		else $error("result register not loaded on emit");

endmodule

/* test/ll1_predictive_parse_engine_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ll1_predictive_parse_engine_top_tb
// Self-checking bench for the LL(1) parse engine: loads a full parse table and
// production store, runs directed and grammar-guided random parses under
// random stalls on both channels, and checks each result against a predictor.
// ----------------------------------------------------------------------------
module ll1_predictive_parse_engine_top_tb;
	import ll1p_pkg::*;

	localparam int N_NT    = 16;
	localparam int N_TERM  = 32;
	localparam int N_PROD  = 64;
	localparam int P_LEN   = 8;
	localparam int S_DEPTH = 64;
	localparam logic [KIND_W-1:0] CELL_CONFLICT = 2'd2;
	localparam logic [KIND_W-1:0] CELL_ODD      = 2'd3;
	localparam logic [OP_W-1:0]   OP_SPARE_A    = 3'd6;
	localparam logic [OP_W-1:0]   OP_SPARE_B    = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [NT_W-1:0]   nonterminal;
		logic [TERM_W-1:0] terminal;
		logic [KIND_W-1:0] cell_kind;
		logic [PROD_W-1:0] prod_index;
		logic [POS_W-1:0]  position;
		logic [SYM_W-1:0]  symbol;
		logic [LEN_W-1:0]  length;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IERR_W-1:0]   item_errors;
		logic [TERR_W-1:0]   total_errors;
		logic [EKIND_W-1:0]  last_error_kind;
		logic [SYM_W-1:0]    last_error_top;
		logic [STEP_W-1:0]   steps_used;
	} parse_res_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_idx;
	logic [CFG_W-1:0] wr_data;

	ll1p_cmd_if cmd();
	ll1p_res_if res();

	ll1_predictive_parse_engine_top dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .res(res.source),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// parser state as the engine should hold it
	logic [7:0]        tbl [N_NT*N_TERM];
	logic [SYM_W-1:0]  psym [N_PROD*P_LEN];
	logic [LEN_W-1:0]  plen [N_PROD];
	logic [SYM_W-1:0]  stk [S_DEPTH];
	int unsigned       sp;
	int unsigned       steps;
	int unsigned       err_total;
	int unsigned       item_errs;
	logic [EKIND_W-1:0] err_kind;
	logic [SYM_W-1:0]  err_top;
	bit                parsing;
	logic [3:0]        start_nt;
	int unsigned       limit;

	parse_res_t pending_q[$];
	int  fails;
	int  n_items;
	int  n_results;
	int  n_accept;
	int  n_reject;
	bit  hold_req;
	bit  no_gaps;

	function automatic parse_res_t snap(logic [STATUS_W-1:0] st);
		parse_res_t r;
		r.status          = st;
		r.item_errors     = item_errs[IERR_W-1:0];
		r.total_errors    = err_total[TERR_W-1:0];
		r.last_error_kind = err_kind;
		r.last_error_top  = err_top;
		r.steps_used      = steps[STEP_W-1:0];
		return r;
	endfunction

	function automatic void log_error(logic [EKIND_W-1:0] k, logic [SYM_W-1:0] top);
		if (item_errs < IERR_MAX) item_errs++;
		if (err_total < TERR_MAX) err_total++;
		err_kind = k;
		err_top  = top;
	endfunction

	function automatic parse_res_t run_parse(bit at_end, logic [TERM_W-1:0] tok);
		logic [SYM_W-1:0] a;
		logic [SYM_W-1:0] x;
		logic [SYM_W-1:0] top;
		logic [7:0] cell_v;
		logic [1:0] kind;
		logic [PROD_W-1:0] p;
		int unsigned len;
		int unsigned row;
		bit consumed;
		a = at_end ? SYM_END_MARK : SYM_W'(tok);
		forever begin
			consumed = 1'b0;
			if (steps < STEP_MAX) steps++;
			if (sp == 0) begin
				parsing = 1'b0;
				return snap(ST_REJECT);
			end
			x = stk[sp-1];
			if (x == SYM_END_MARK && a == SYM_END_MARK) begin
				parsing = 1'b0;
				return snap(ST_ACCEPT);
			end
			if (x < NT_BASE) begin
				sp--;
				if (x == a) consumed = 1'b1;
				else begin
					log_error(ERR_MISMATCH, x);
					if (!at_end) consumed = 1'b1;
				end
			end else begin
				row    = x - NT_BASE;
				cell_v = (row < N_NT) ? tbl[row*N_TERM + a] : 8'd0;
				kind   = cell_v[7:6];
				p      = cell_v[5:0];
				if (kind == CELL_EMPTY) begin
					log_error(ERR_EMPTY, x);
					if (at_end) begin
						parsing = 1'b0;
						return snap(ST_REJECT);
					end
					consumed = 1'b1;
				end else if (kind >= CELL_CONFLICT) begin
					log_error(ERR_CONFLICT, x);
					if (!at_end) consumed = 1'b1;
				end else begin
					len = plen[p];
					sp--;
					if (sp + len > S_DEPTH) begin
						log_error(ERR_OVERFLOW, x);
						parsing = 1'b0;
						return snap(ST_REJECT);
					end
					for (int i = len; i > 0; i--) begin
						stk[sp] = psym[p*P_LEN + i - 1];
						sp++;
					end
				end
			end
			if (steps > limit || steps >= STEP_MAX) begin
				top = sp ? stk[sp-1] : x;
				log_error(ERR_LIMIT, top);
				parsing = 1'b0;
				return snap(ST_REJECT);
			end
			if (consumed) return snap(ST_OK);
		end
	endfunction

	// returns 1 when the item gives a result
	function automatic bit predict_item(cmd_t c, output parse_res_t r);
		int unsigned l;
		item_errs = 0;
		r = '0;
		case (c.op)
			OP_LOAD_CELL: begin
				tbl[c.nonterminal*N_TERM + c.terminal] = {c.cell_kind, c.prod_index};
				return 1'b0;
			end
			OP_LOAD_SYM: begin
				psym[c.prod_index*P_LEN + c.position] = c.symbol;
				return 1'b0;
			end
			OP_LOAD_LEN: begin
				l = (c.length > P_LEN) ? P_LEN : c.length;
				plen[c.prod_index] = LEN_W'(l);
				return 1'b0;
			end
			OP_START: begin
				stk[0] = SYM_END_MARK;
				stk[1] = NT_BASE + SYM_W'(start_nt);
				sp = 2;
				steps = 0;
				err_total = 0;
				err_kind = ERR_NONE;
				err_top = '0;
				parsing = 1'b1;
				r = snap(ST_OK);
				return 1'b1;
			end
			OP_TOKEN, OP_END: begin
				if (!parsing) r = snap(ST_IDLE);
				else r = run_parse(c.op == OP_END, c.terminal);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic cmd_t noise_fields(logic [OP_W-1:0] op);
		cmd_t c;
		c = cmd_t'($bits(cmd_t)'({$urandom, $urandom}));
		c.op = op;
		if (c.symbol > 47) c.symbol = c.symbol - 16;
		return c;
	endfunction

	// one transfer on the input channel, then its expectation is queued
	task automatic send_cmd(cmd_t c);
		parse_res_t r;
		int g;
		g = pick_gap();
		if (g > 0) begin
			cmd.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.op          <= c.op;
		cmd.nonterminal <= c.nonterminal;
		cmd.terminal    <= c.terminal;
		cmd.cell_kind   <= c.cell_kind;
		cmd.prod_index  <= c.prod_index;
		cmd.position    <= c.position;
		cmd.symbol      <= c.symbol;
		cmd.length      <= c.length;
		do @(posedge clk); while (!cmd.ready);
		n_items++;
		if (predict_item(c, r)) pending_q = {pending_q, r};
	endtask

	task automatic send_op(logic [OP_W-1:0] op, logic [TERM_W-1:0] t);
		cmd_t c;
		c = noise_fields(op);
		c.terminal = t;
		send_cmd(c);
	endtask

	task automatic load_cell(int nt, int t, logic [KIND_W-1:0] k, int p);
		cmd_t c;
		c = noise_fields(OP_LOAD_CELL);
		c.nonterminal = NT_W'(nt);
		c.terminal = TERM_W'(t);
		c.cell_kind = k;
		c.prod_index = PROD_W'(p);
		send_cmd(c);
	endtask

	// symbols are written before the length so no unwritten symbol is read
	task automatic load_prod(int p, logic [LEN_W-1:0] len, logic [SYM_W-1:0] s[P_LEN]);
		cmd_t c;
		int n;
		n = (len > P_LEN) ? P_LEN : len;
		for (int i = 0; i < n; i++) begin
			c = noise_fields(OP_LOAD_SYM);
			c.prod_index = PROD_W'(p);
			c.position = POS_W'(i);
			c.symbol = s[i];
			send_cmd(c);
		end
		c = noise_fields(OP_LOAD_LEN);
		c.prod_index = PROD_W'(p);
		c.length = len;
		send_cmd(c);
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
		wait_drained();
		wr_en   <= 1'b1;
		wr_idx  <= idx;
		wr_data <= CFG_W'(v);
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_START_SYMBOL) start_nt = v[3:0];
		else limit = v[STEP_W-1:0];
		@(posedge clk);
	endtask

	function automatic logic [SYM_W-1:0] rand_sym();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return SYM_W'($urandom_range(1, 31));
		if (r < 97) return SYM_W'($urandom_range(32, 46));
		if (r < 99) return 6'd47;
		return SYM_END_MARK;
	endfunction

	// a token that the current stack top can take, most of the time
	function automatic logic [TERM_W-1:0] likely_token();
		logic [SYM_W-1:0] x;
		int unsigned row;
		int cols[$];
		if (!parsing || sp == 0 || $urandom_range(0, 9) == 0)
			return TERM_W'($urandom_range(0, 31));
		x = stk[sp-1];
		if (x < NT_BASE)
			return (x == SYM_END_MARK) ? TERM_W'($urandom_range(1, 31)) : x[4:0];
		row = x - NT_BASE;
		for (int t = 1; t < N_TERM; t++)
			if (tbl[row*N_TERM + t][7:6] == CELL_SINGLE) cols = {cols, t};
		if (cols.size() == 0) return TERM_W'($urandom_range(1, 31));
		return TERM_W'(cols[$urandom_range(0, cols.size()-1)]);
	endfunction

	// whole table and every production are written, so no read is undefined
	task automatic test_load_store();
		logic [SYM_W-1:0] s[P_LEN];
		int r;
		logic [KIND_W-1:0] k;
		for (int p = 0; p < N_PROD; p++) begin
			for (int i = 0; i < P_LEN; i++) s[i] = rand_sym();
			r = $urandom_range(0, 9);
			load_prod(p, (r < 3) ? LEN_W'(0) : (r < 9) ? LEN_W'($urandom_range(1, 3))
				: LEN_W'($urandom_range(4, 15)), s);
		end
		for (int nt = 0; nt < N_NT; nt++)
			for (int t = 0; t < N_TERM; t++) begin
				r = $urandom_range(0, 19);
				k = (r < 2) ? CELL_EMPTY : (r < 3) ? CELL_CONFLICT : (r < 4) ? CELL_ODD
					: CELL_SINGLE;
				load_cell(nt, t, k, $urandom_range(0, N_PROD-1));
			end
		// directed grammar on rows 0..2 and 15
		s = '{6'd1, 6'd33, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
		load_prod(0, 2, s);
		load_prod(1, 0, s);
		s = '{6'd2, 6'd2, 6'd2, 6'd2, 6'd2, 6'd2, 6'd2, 6'd2};
		load_prod(2, 1, s);
		s = '{6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47, 6'd47};
		load_prod(63, 15, s);
		load_cell(0, 1, CELL_SINGLE, 0);
		load_cell(0, 0, CELL_SINGLE, 1);
		load_cell(1, 2, CELL_SINGLE, 2);
		load_cell(1, 0, CELL_SINGLE, 1);
		load_cell(1, 3, CELL_CONFLICT, 0);
		load_cell(1, 4, CELL_EMPTY, 0);
		load_cell(2, 0, CELL_CONFLICT, 63);
		load_cell(15, 31, CELL_SINGLE, 63);
		send_op(OP_SPARE_A, 0);
		send_op(OP_SPARE_B, 31);
	endtask

	task automatic test_no_parse();
		send_op(OP_TOKEN, 5);
		send_op(OP_END, 0);
	endtask

	task automatic test_directed();
		write_reg(REG_START_SYMBOL, 0);
		send_op(OP_START, 0);
		send_op(OP_TOKEN, 1);
		send_op(OP_TOKEN, 2);
		send_op(OP_END, 0);
		// conflict, empty cell, then a mismatch on the end marker
		send_op(OP_START, 0);
		send_op(OP_TOKEN, 1);
		send_op(OP_TOKEN, 3);
		send_op(OP_TOKEN, 4);
		send_op(OP_TOKEN, 2);
		send_op(OP_TOKEN, 5);
		send_op(OP_END, 0);
		send_op(OP_TOKEN, 1);
		// self-expanding production overflows the stack
		write_reg(REG_START_SYMBOL, 15);
		send_op(OP_START, 0);
		send_op(OP_TOKEN, 31);
		// conflict at end of input runs into the step limit
		write_reg(REG_START_SYMBOL, 2);
		write_reg(REG_STEP_LIMIT, 1);
		send_op(OP_START, 0);
		send_op(OP_END, 0);
		write_reg(REG_STEP_LIMIT, 16383);
		send_op(OP_START, 0);
		send_op(OP_END, 0);
		write_reg(REG_STEP_LIMIT, 10000);
		write_reg(REG_START_SYMBOL, 0);
	endtask

	task automatic test_backpressure();
		send_op(OP_START, 0);
		hold_req = 1'b1;
		no_gaps = 1'b1;
		repeat (30) send_op(OP_TOKEN, likely_token());
		no_gaps = 1'b0;
		wait_drained();
		send_op(OP_END, 0);
	endtask

	task automatic test_random(int n);
		int sent;
		int ntok;
		sent = 0;
		while (sent < n) begin
			write_reg(REG_START_SYMBOL, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0);
			write_reg(REG_STEP_LIMIT, $urandom_range(20, 300));
			no_gaps = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(2, 5)) begin
				send_op(OP_START, 0);
				ntok = $urandom_range(1, 12);
				for (int i = 0; i < ntok; i++) begin
					case ($urandom_range(0, 19))
						0: send_op(OP_TOKEN, TERM_W'($urandom_range(0, 31)));
						1: load_cell($urandom_range(0, 15), $urandom_range(0, 31),
							KIND_W'($urandom_range(0, 3)), $urandom_range(0, 63));
						2: send_op(($urandom_range(0, 1)) ? OP_SPARE_A : OP_SPARE_B, 0);
						default: send_op(OP_TOKEN, likely_token());
					endcase
				end
				sent += ntok + 2;
				if ($urandom_range(0, 7) != 0) send_op(OP_END, 0);
				else send_op(OP_START, 0);
			end
			no_gaps = 1'b0;
		end
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		int stall;
		res.ready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
				res.ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				res.ready <= 1'b0;
			end else begin
				stall = pick_gap();
				res.ready <= (stall == 0);
			end
		end
	end

	always @(posedge clk) begin
		parse_res_t e;
		if (res.valid && res.ready) begin
			n_results++;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result status=%0d", $time, res.status);
				fails++;
			end else begin
				e = pending_q.pop_front();
				if (e.status == ST_ACCEPT) n_accept++;
				if (e.status == ST_REJECT) n_reject++;
				if (res.status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, res.status);
					fails++;
				end
				if (res.item_errors !== e.item_errors) begin
					$display("%0t: item_errors exp %0d got %0d", $time, e.item_errors,
						res.item_errors);
					fails++;
				end
				if (res.total_errors !== e.total_errors) begin
					$display("%0t: total_errors exp %0d got %0d", $time, e.total_errors,
						res.total_errors);
					fails++;
				end
				if (res.last_error_kind !== e.last_error_kind) begin
					$display("%0t: last_error_kind exp %0d got %0d", $time, e.last_error_kind,
						res.last_error_kind);
					fails++;
				end
				if (res.last_error_top !== e.last_error_top) begin
					$display("%0t: last_error_top exp %0d got %0d", $time, e.last_error_top,
						res.last_error_top);
					fails++;
				end
				if (res.steps_used !== e.steps_used) begin
					$display("%0t: steps_used exp %0d got %0d", $time, e.steps_used,
						res.steps_used);
					fails++;
				end
			end
		end
	end

	initial begin
		#100ms;
		$display("[ll1_predictive_parse_engine_top] ERROR");
		$finish;
	end

	initial begin
		int guard;
		fails = 0; n_items = 0; n_results = 0; n_accept = 0; n_reject = 0;
		hold_req = 1'b0; no_gaps = 1'b0;
		sp = 0; steps = 0; err_total = 0; item_errs = 0; err_kind = ERR_NONE; err_top = '0;
		parsing = 1'b0; start_nt = '0; limit = LIMIT_RST;
		arst_n = 1'b0;
		wr_en = 1'b0; wr_idx = '0; wr_data = '0;
		cmd.valid = 1'b0; cmd.op = '0; cmd.nonterminal = '0; cmd.terminal = '0;
		cmd.cell_kind = '0; cmd.prod_index = '0; cmd.position = '0; cmd.symbol = '0;
		cmd.length = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_parse();
		test_load_store();
		test_directed();
		test_backpressure();
		// table and store loads above already account for most of the items
		test_random(80);
		cmd.valid <= 1'b0;
		guard = 0;
		while (pending_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
		$display("%0d items sent, %0d results checked (%0d accepts, %0d rejects)",
			n_items, n_results, n_accept, n_reject);
		$display("covered table/production loads, recovery paths, overflow, step limits");
		if (fails == 0 && pending_q.size() == 0) begin
			$display("[ll1_predictive_parse_engine_top] OK");
		end else begin
			$display("%0d failures, %0d results still missing", fails, pending_q.size());
			$display("[ll1_predictive_parse_engine_top] ERROR");
		end
		$finish;
	end

endmodule

/* ll1_predictive_parse_engine_top.f */
design/ll1p_pkg.sv
design/ll1p_cmd_if.sv
design/ll1p_res_if.sv
design/ll1p_err_rec.sv
design/ll1_predictive_parse_engine_top.sv
test/ll1_predictive_parse_engine_top_tb.sv
